// ===== sv/shp3_pkg.sv =====
// Shared types, constants and kernel arithmetic for the 3x3 RGB sharpen core.
package shp3_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned IMG_W_BITS    = 11;
  localparam int unsigned IMG_H_BITS    = 13;
  localparam int unsigned ROW_BITS      = 12;
  localparam int unsigned CFG_DW        = 13;
  localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 11'd640;
  localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 13'd480;

  localparam int unsigned OUT_Q_DEPTH = 3;
  localparam int unsigned OUT_Q_CW    = $clog2(OUT_Q_DEPTH + 1);
  localparam int unsigned OUT_Q_PW    = $clog2(OUT_Q_DEPTH);

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic last;
    rgb_t px;
  } out_item_t;

  // 9*ctr minus the eight neighbors, clamped to a byte
  function automatic logic [7:0] sharpen_ch(logic [7:0] ctr, logic [7:0][7:0] nb);
    logic [11:0]        nine;
    logic [10:0]        acc;
    logic signed [12:0] diff;
    logic [7:0]         res;
    nine = {1'b0, ctr, 3'b000} + {4'b0000, ctr};
    acc  = '0;
    for (int i = 0; i < 8; i++) begin
      acc = acc + {3'b000, nb[i]};
    end
    diff = $signed({1'b0, nine}) - $signed({2'b00, acc});
    if (diff < 0) begin
      res = '0;
    end else if (diff > 13'sd255) begin
      res = 8'hFF;
    end else begin
      res = diff[7:0];
    end
    return res;
  endfunction

  function automatic rgb_t sharpen_px(rgb_t ctr, rgb_t [7:0] nb);
    logic [7:0][7:0] r;
    logic [7:0][7:0] g;
    logic [7:0][7:0] b;
    rgb_t            res;
    for (int i = 0; i < 8; i++) begin
      r[i] = nb[i].red;
      g[i] = nb[i].green;
      b[i] = nb[i].blue;
    end
    res.red   = sharpen_ch(ctr.red, r);
    res.green = sharpen_ch(ctr.green, g);
    res.blue  = sharpen_ch(ctr.blue, b);
    return res;
  endfunction

endpackage

// ===== sv/sharpen_3x3_rgb_core.sv =====
// Streaming 3x3 sharpen filter on RGB pixels with two line stores and a 3x3 window.
//
//  port group     dir  payload
//  s_axis_*       in   tdata = {blue, green, red}, tuser = op (pixel / drain)
//  m_axis_*       out  tdata = {blue, green, red}, tlast = frame_last
//  cfg_*          in   write enable, register index, write data (13 bits)
//
// One request per clock while ready is high; a result passes the pipeline register
// and the output queue and leaves when the output side is ready. The line stores
// take one read and one write per cycle, which sets that rate; back-to-back hits
// on one column are forwarded. Reset clears counters, window and queue; line stores
// are left unknown. Input ready drops only when the 3-entry output queue plus the
// in-flight result could overflow.
module sharpen_3x3_rgb_core #(
  parameter int unsigned MAX_WIDTH = shp3_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // slave stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // in_red, in_green, in_blue
  input  logic                        s_axis_tuser,  // op
  // master stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // out_red, out_green, out_blue
  output logic                        m_axis_tlast,
  // configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [shp3_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW = $clog2(MAX_WIDTH + 2);
  localparam int unsigned HW = shp3_pkg::IMG_H_BITS;
  localparam int unsigned RW = shp3_pkg::ROW_BITS;
  localparam int unsigned QC = shp3_pkg::OUT_Q_CW;

  // ---------------- configuration ----------------
  logic [shp3_pkg::IMG_W_BITS-1:0] img_w_q;
  logic [HW-1:0]                   img_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= shp3_pkg::IMG_W_RESET;
      img_h_q <= shp3_pkg::IMG_H_RESET;
    end else if (cfg_we_i) begin
      unique case (shp3_pkg::cfg_reg_e'(cfg_idx_i))
        shp3_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[shp3_pkg::IMG_W_BITS-1:0];
        shp3_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg_data_i[HW-1:0];
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [AW-1:0] wm1;
  logic [RW-1:0] hm1;

  always_comb begin
    if (img_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(img_w_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(img_w_q);
    end
    if (img_h_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(img_h_q) > 32'(shp3_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(shp3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = img_h_q;
    end
    wm1 = AW'(w_eff - WW'(1));
    hm1 = RW'(h_eff - HW'(1));
  end

  // ---------------- request stage ----------------
  logic          in_acc;
  shp3_pkg::op_e op;
  logic          is_pix;

  logic [AW-1:0] in_col_q, in_col_d, col0;
  logic [RW-1:0] in_row_q, in_row_d, row0;
  logic [AW-1:0] out_col_q, out_col_d, oc0;
  logic [RW-1:0] out_row_q, out_row_d, or0;
  logic [PW-1:0] pend_q, pend_d, d_full;
  logic [WW-1:0] d_c;
  logic [AW-1:0] lc, dr_addr, rd_addr;
  logic          near, dr_sel2, pix_emit, has_pend, s0_emit, border, last;

  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign op     = shp3_pkg::op_e'(s_axis_tuser);
  assign is_pix = (op == shp3_pkg::OP_PIXEL);

  always_comb begin
    // counters left beyond a shrunken frame wrap to zero
    col0 = (WW'(in_col_q) >= w_eff) ? '0 : in_col_q;
    row0 = (HW'(in_row_q) >= h_eff) ? '0 : in_row_q;
    oc0  = (WW'(out_col_q) >= w_eff) ? '0 : out_col_q;
    or0  = (HW'(out_row_q) >= h_eff) ? '0 : out_row_q;

    pix_emit = pend_q > PW'(w_eff);
    has_pend = pend_q != '0;

    // drain: locate the oldest pending pixel in the line stores
    d_full  = pend_q - PW'(1);
    d_c     = (d_full > PW'(w_eff)) ? w_eff : WW'(d_full);
    lc      = (col0 == '0) ? wm1 : col0 - AW'(1);
    near    = d_c <= WW'(lc);
    dr_addr = near ? AW'(WW'(lc) - d_c) : AW'(w_eff + WW'(lc) - d_c);
    dr_sel2 = !near && (d_c == w_eff);

    rd_addr = is_pix ? col0 : dr_addr;
    s0_emit = is_pix ? pix_emit : has_pend;
    border  = (or0 == '0) || (or0 == hm1) || (oc0 == '0) || (oc0 == wm1);
    last    = (or0 == hm1) && (oc0 == wm1);

    in_col_d = col0;
    in_row_d = row0;
    if (is_pix) begin
      if (col0 == wm1) begin
        in_col_d = '0;
        in_row_d = (row0 == hm1) ? '0 : row0 + RW'(1);
      end else begin
        in_col_d = col0 + AW'(1);
      end
    end

    if (is_pix) begin
      pend_d = pix_emit ? pend_q : pend_q + PW'(1);
    end else begin
      pend_d = has_pend ? d_full : pend_q;
    end

    if (oc0 == wm1) begin
      out_col_d = '0;
      out_row_d = (or0 == hm1) ? '0 : or0 + RW'(1);
    end else begin
      out_col_d = oc0 + AW'(1);
      out_row_d = or0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else if (in_acc) begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      pend_q   <= pend_d;
      if (s0_emit) begin
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
      end
    end
  end

  // ---------------- line stores ----------------
  logic            s1_valid_q, s1_emit_q, s1_pix_q;
  logic            s1_kern_q, s1_last_q, s1_sel2_q;
  logic [AW-1:0]   s1_addr_q;
  shp3_pkg::rgb_t  s1_px_q;
  shp3_pkg::rgb_t  rd_prev, rd_prev2;
  logic            s1_wr;
  shp3_pkg::rgb_t  mid, top;

  assign s1_wr = s1_valid_q & s1_pix_q;

  shp3_line_ram #(.DEPTH(MAX_WIDTH)) u_prev (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_px_q),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (rd_prev)
  );

  shp3_line_ram #(.DEPTH(MAX_WIDTH)) u_prev2 (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (s1_addr_q),
    .wdata_i (mid),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (rd_prev2)
  );

  // ---------------- pipeline register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      s1_pix_q   <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      if (in_acc) begin
        s1_emit_q <= s0_emit;
        s1_pix_q  <= is_pix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q <= rd_addr;
      s1_kern_q <= !border;
      s1_last_q <= last;
      s1_sel2_q <= dr_sel2;
      s1_px_q   <= '{blue: s_axis_tdata[23:16], green: s_axis_tdata[15:8],
                     red: s_axis_tdata[7:0]};
    end
  end

  // write made in the cycle of our read is not in the read data yet
  logic            fwd_we_q;
  logic [AW-1:0]   fwd_addr_q;
  shp3_pkg::rgb_t  fwd_prev_q, fwd_prev2_q;
  logic            fwd_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_we_q <= 1'b0;
    end else begin
      fwd_we_q <= s1_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q  <= s1_addr_q;
    fwd_prev_q  <= s1_px_q;
    fwd_prev2_q <= mid;
  end

  assign fwd_hit = fwd_we_q && (fwd_addr_q == s1_addr_q);
  assign mid     = fwd_hit ? fwd_prev_q  : rd_prev;
  assign top     = fwd_hit ? fwd_prev2_q : rd_prev2;

  // ---------------- window and kernel ----------------
  shp3_pkg::rgb_t [2:0][2:0] win_q;
  shp3_pkg::rgb_t [7:0]      nb;
  shp3_pkg::rgb_t            sharp, res_px;
  shp3_pkg::out_item_t       push_item;
  logic                      s1_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_wr) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= top;
      win_q[1][2] <= mid;
      win_q[2][2] <= s1_px_q;
    end
  end

  // neighbors of the window after this pixel's shift; center is win_q[1][2]
  always_comb begin
    nb[0] = win_q[0][1];
    nb[1] = win_q[0][2];
    nb[2] = top;
    nb[3] = win_q[1][1];
    nb[4] = mid;
    nb[5] = win_q[2][1];
    nb[6] = win_q[2][2];
    nb[7] = s1_px_q;
    sharp = shp3_pkg::sharpen_px(win_q[1][2], nb);
    if (!s1_pix_q) begin
      res_px = s1_sel2_q ? top : mid;
    end else if (s1_kern_q) begin
      res_px = sharp;
    end else begin
      res_px = win_q[1][2];
    end
  end

  assign s1_push        = s1_valid_q & s1_emit_q;
  assign push_item.last = s1_last_q;
  assign push_item.px   = res_px;

  // ---------------- output queue ----------------
  shp3_pkg::out_item_t pop_item;
  logic [QC-1:0]       q_cnt;

  shp3_out_fifo u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_push),
    .push_item_i (push_item),
    .pop_valid_o (m_axis_tvalid),
    .pop_item_o  (pop_item),
    .pop_ready_i (m_axis_tready),
    .count_o     (q_cnt)
  );

  assign m_axis_tdata = {pop_item.px.blue, pop_item.px.green, pop_item.px.red};
  assign m_axis_tlast = pop_item.last;

  // room for the in-flight result and the one this request may cause
  assign s_axis_tready =
    ((3'(q_cnt) + 3'(s1_push)) < 3'(shp3_pkg::OUT_Q_DEPTH));

  // ---------------- assertions ----------------
  a_q_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_push |-> (q_cnt < QC'(shp3_pkg::OUT_Q_DEPTH)))
    else $error("output queue overflow");

  a_q_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt == QC'(shp3_pkg::OUT_Q_DEPTH)) |-> !s_axis_tready)
    else $error("request taken with full output queue");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_we_i) |=> (WW'(in_col_q) < w_eff))
    else $error("input column beyond frame width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_we_i) |=> (HW'(in_row_q) < h_eff))
    else $error("input row beyond frame height");

endmodule

// ===== sv/shp3_line_ram.sv =====
// Line store: single-port-write, single-port-read RAM, read-first, registered read.
module shp3_line_ram #(
  parameter int unsigned DEPTH = shp3_pkg::MAX_WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  shp3_pkg::rgb_t  wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output shp3_pkg::rgb_t  rdata_o
);

  shp3_pkg::rgb_t mem [DEPTH];
  shp3_pkg::rgb_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/shp3_out_fifo.sv =====
// Small output queue that decouples the filter pipeline from the result stream.
module shp3_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  shp3_pkg::out_item_t           push_item_i,
  output logic                          pop_valid_o,
  output shp3_pkg::out_item_t           pop_item_o,
  input  logic                          pop_ready_i,
  output logic [shp3_pkg::OUT_Q_CW-1:0] count_o
);

  localparam int unsigned DEPTH = shp3_pkg::OUT_Q_DEPTH;
  localparam int unsigned PW    = shp3_pkg::OUT_Q_PW;
  localparam int unsigned CW    = shp3_pkg::OUT_Q_CW;

  shp3_pkg::out_item_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    cnt_d = cnt_q + CW'(push_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign pop_valid_o = (cnt_q != '0);
  assign pop_item_o  = mem_q[rd_ptr_q];
  assign count_o     = cnt_q;

endmodule
